// File: hdl/ugd_pkg.sv
// ----------------------------------------------------------------------------
// ugd_pkg: shared types and constants for the UTF-8 / GBK detector
// Byte constants, window sizing and the scanner state record.
// ----------------------------------------------------------------------------
package ugd_pkg;

  localparam int SAMPLE_BYTES = 4096;
  localparam int WIN_W        = $clog2(SAMPLE_BYTES + 1);

  localparam logic [7:0] BOM_B0        = 8'hef;
  localparam logic [7:0] BOM_B1        = 8'hbb;
  localparam logic [7:0] BOM_B2        = 8'hbf;
  localparam logic [7:0] HIGH_MIN      = 8'h80;
  localparam logic [7:0] U2_LEAD_MIN   = 8'hc2;
  localparam logic [7:0] U2_LEAD_MAX   = 8'hdf;
  localparam logic [7:0] U3_LEAD_MIN   = 8'he0;
  localparam logic [7:0] U3_LEAD_MAX   = 8'hef;
  localparam logic [7:0] U4_LEAD_MIN   = 8'hf0;
  localparam logic [7:0] U4_LEAD_MAX   = 8'hf4;
  localparam logic [7:0] U3_LEAD_E0    = 8'he0;
  localparam logic [7:0] U3_LEAD_ED    = 8'hed;
  localparam logic [7:0] BOUND_90      = 8'h90;
  localparam logic [7:0] BOUND_A0      = 8'ha0;
  localparam logic [7:0] GBK_LEAD_MIN  = 8'h81;
  localparam logic [7:0] GBK_LEAD_MAX  = 8'hfe;
  localparam logic [7:0] GBK_TRAIL_MIN = 8'h40;
  localparam logic [7:0] GBK_TRAIL_MAX = 8'hfe;
  localparam logic [7:0] GBK_TRAIL_BAD = 8'h7f;

  localparam logic ENC_UTF8 = 1'b0;
  localparam logic ENC_GBK  = 1'b1;

  typedef struct packed {
    logic [7:0] utf8_lead;
    logic [1:0] utf8_remaining;
    logic       utf8_pending_error;
    logic       utf8_failed;
    logic       gbk_expect_trail;
    logic       gbk_failed;
  } scan_state_t;

  // total sequence length for a lead byte, zero if not a legal lead
  function automatic logic [2:0] seq_length(input logic [7:0] lead);
    logic [2:0] len;
    len = 3'd0;
    if (lead >= U2_LEAD_MIN && lead <= U2_LEAD_MAX) len = 3'd2;
    else if (lead >= U3_LEAD_MIN && lead <= U3_LEAD_MAX) len = 3'd3;
    else if (lead >= U4_LEAD_MIN && lead <= U4_LEAD_MAX) len = 3'd4;
    return len;
  endfunction

endpackage

// File: hdl/utf8_gbk_encoding_detector_unit.sv
// ----------------------------------------------------------------------------
// utf8_gbk_encoding_detector_unit: UTF-8 / GBK text encoding detector
// Scans a file one byte per beat and reports the encoding after the last byte.
// The verdict is registered: it is valid in the cycle after the beat carrying last_byte.
// Throughput: one byte per cycle unless a waiting verdict with out_ready low stalls it;
// the per-byte state update is one register stage, and the verdict register is emptied in the same cycle it is taken.
// Reset: synchronous rst clears all scan state and the output valid.
// ----------------------------------------------------------------------------
module utf8_gbk_encoding_detector_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       encoding,
  output logic       has_bom
);

  typedef enum logic [1:0] {POS_START, POS_EF, POS_EFBB, POS_DONE} pos_t;

  pos_t                      pos, pos_next;
  logic                      bom_seen, bom_seen_next;
  logic                      high_seen, high_seen_next;
  logic [ugd_pkg::WIN_W-1:0] win_count, win_count_next;
  ugd_pkg::scan_state_t      scan, scan_out, scan_next;
  logic                      in_window;
  logic                      in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  ugd_scan u_scan (
    .data_byte (data_byte),
    .cur       (scan),
    .nxt       (scan_out)
  );

  always_comb begin
    pos_next      = pos;
    bom_seen_next = bom_seen;
    unique case (pos)
      POS_START: pos_next = (data_byte == ugd_pkg::BOM_B0) ? POS_EF : POS_DONE;
      POS_EF:    pos_next = (data_byte == ugd_pkg::BOM_B1) ? POS_EFBB : POS_DONE;
      POS_EFBB: begin
        if (data_byte == ugd_pkg::BOM_B2) bom_seen_next = 1'b1;
        pos_next = POS_DONE;
      end
      POS_DONE:  pos_next = POS_DONE;
      default:   pos_next = POS_DONE;
    endcase
  end

  // window opens at the first high byte and closes after SAMPLE_BYTES bytes
  assign in_window      = (high_seen || data_byte >= ugd_pkg::HIGH_MIN) &&
                          (win_count < ugd_pkg::WIN_W'(ugd_pkg::SAMPLE_BYTES));
  assign high_seen_next = high_seen || in_window;
  assign win_count_next = in_window ? win_count + ugd_pkg::WIN_W'(1) : win_count;
  assign scan_next      = in_window ? scan_out : scan;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_START;
      bom_seen  <= 1'b0;
      high_seen <= 1'b0;
      win_count <= '0;
      scan      <= '0;
      out_valid <= 1'b0;
      encoding  <= ugd_pkg::ENC_UTF8;
      has_bom   <= 1'b0;
    end else begin
      if (in_fire && last_byte) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (in_fire) begin
        if (last_byte) begin
          has_bom   <= bom_seen_next;
          if (!bom_seen_next && high_seen_next &&
              scan_next.utf8_failed && !scan_next.gbk_failed)
            encoding <= ugd_pkg::ENC_GBK;
          else
            encoding <= ugd_pkg::ENC_UTF8;
          // next beat starts a new file
          pos       <= POS_START;
          bom_seen  <= 1'b0;
          high_seen <= 1'b0;
          win_count <= '0;
          scan      <= '0;
        end else begin
          pos       <= pos_next;
          bom_seen  <= bom_seen_next;
          high_seen <= high_seen_next;
          win_count <= win_count_next;
          scan      <= scan_next;
        end
      end
    end
  end

endmodule

// File: hdl/ugd_scan.sv
// ----------------------------------------------------------------------------
// ugd_scan: per-byte UTF-8 and GBK checker
// Next-state logic for both validity checks on one window byte.
// ----------------------------------------------------------------------------
module ugd_scan (
  input  logic [7:0]           data_byte,
  input  ugd_pkg::scan_state_t cur,
  output ugd_pkg::scan_state_t nxt
);

  logic [2:0] lead_len;
  logic [2:0] byte_len;
  logic       second;
  logic       bad;

  assign lead_len = ugd_pkg::seq_length(cur.utf8_lead);
  assign byte_len = ugd_pkg::seq_length(data_byte);
  assign second   = (lead_len != 3'd0) &&
                    ({1'b0, cur.utf8_remaining} == lead_len - 3'd1);

  always_comb begin
    bad = (data_byte[7:6] != 2'b10);
    if (second) begin
      if (cur.utf8_lead == ugd_pkg::U3_LEAD_E0 && data_byte < ugd_pkg::BOUND_A0) bad = 1'b1;
      if (cur.utf8_lead == ugd_pkg::U3_LEAD_ED && data_byte >= ugd_pkg::BOUND_A0) bad = 1'b1;
      if (cur.utf8_lead == ugd_pkg::U4_LEAD_MIN && data_byte < ugd_pkg::BOUND_90) bad = 1'b1;
      if (cur.utf8_lead == ugd_pkg::U4_LEAD_MAX && data_byte >= ugd_pkg::BOUND_90) bad = 1'b1;
    end
  end

  always_comb begin
    nxt = cur;
    // UTF-8: errors inside a sequence only commit when it completes
    if (cur.utf8_remaining == 2'd0) begin
      if (data_byte >= ugd_pkg::HIGH_MIN) begin
        if (byte_len == 3'd0) begin
          nxt.utf8_failed = 1'b1;
        end else begin
          nxt.utf8_lead          = data_byte;
          nxt.utf8_remaining     = 2'(byte_len - 3'd1);
          nxt.utf8_pending_error = 1'b0;
        end
      end
    end else begin
      nxt.utf8_remaining = cur.utf8_remaining - 2'd1;
      if (cur.utf8_remaining == 2'd1) begin
        if (cur.utf8_pending_error || bad) nxt.utf8_failed = 1'b1;
        nxt.utf8_pending_error = 1'b0;
      end else if (bad) begin
        nxt.utf8_pending_error = 1'b1;
      end
    end

    // GBK lead/trail pairing
    if (cur.gbk_expect_trail) begin
      if (!(data_byte >= ugd_pkg::GBK_TRAIL_MIN && data_byte <= ugd_pkg::GBK_TRAIL_MAX &&
            data_byte != ugd_pkg::GBK_TRAIL_BAD)) nxt.gbk_failed = 1'b1;
      nxt.gbk_expect_trail = 1'b0;
    end else if (data_byte >= ugd_pkg::HIGH_MIN) begin
      if (data_byte >= ugd_pkg::GBK_LEAD_MIN && data_byte <= ugd_pkg::GBK_LEAD_MAX)
        nxt.gbk_expect_trail = 1'b1;
      else
        nxt.gbk_failed = 1'b1;
    end
  end

endmodule

// File: dv/ugd_verdict_checker.sv
// ----------------------------------------------------------------------------
// ugd_verdict_checker: verdict predictor and checker for the encoding detector
// Watches both channels. Every accepted byte goes through a behavioral copy
// of the detector. A beat with last_byte queues the expected verdict, and
// each accepted verdict is compared with the oldest one waiting.
// ----------------------------------------------------------------------------
module ugd_verdict_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       encoding,
  input  logic       has_bom,
  output int         mismatches,
  output int         verdicts_owed
);

  typedef struct packed {
    logic enc;
    logic bom;
  } verdict_t;

  verdict_t verdict_q[$];

  // detector state as the predictor sees it
  logic [1:0]                file_pos;
  logic                      bom_flag;
  logic                      window_open;
  logic [ugd_pkg::WIN_W-1:0] window_bytes;
  logic [7:0]                u8_lead;
  logic [1:0]                u8_left;
  logic                      u8_err_pending;
  logic                      u8_bad;
  logic                      gbk_need_trail;
  logic                      gbk_bad;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    if (b >= ugd_pkg::U4_LEAD_MIN && b <= ugd_pkg::U4_LEAD_MAX) return 3'd4;
    if (b >= ugd_pkg::U3_LEAD_MIN && b <= ugd_pkg::U3_LEAD_MAX) return 3'd3;
    if (b >= ugd_pkg::U2_LEAD_MIN && b <= ugd_pkg::U2_LEAD_MAX) return 3'd2;
    return 3'd0;
  endfunction

  task automatic clear_state();
    file_pos       = 2'd0;
    bom_flag       = 1'b0;
    window_open    = 1'b0;
    window_bytes   = '0;
    u8_lead        = 8'd0;
    u8_left        = 2'd0;
    u8_err_pending = 1'b0;
    u8_bad         = 1'b0;
    gbk_need_trail = 1'b0;
    gbk_bad        = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    logic [2:0] len;
    logic       bad;
    verdict_t   v;
    // BOM only counts on the first three bytes of a file
    if (file_pos == 2'd0) file_pos = (b == ugd_pkg::BOM_B0) ? 2'd1 : 2'd3;
    else if (file_pos == 2'd1) file_pos = (b == ugd_pkg::BOM_B1) ? 2'd2 : 2'd3;
    else if (file_pos == 2'd2) begin
      bom_flag = (b == ugd_pkg::BOM_B2);
      file_pos = 2'd3;
    end

    if ((window_open || b >= ugd_pkg::HIGH_MIN) && window_bytes < ugd_pkg::SAMPLE_BYTES) begin
      window_open  = 1'b1;
      window_bytes = window_bytes + 1'b1;

      if (u8_left == 2'd0) begin
        if (b >= ugd_pkg::HIGH_MIN) begin
          len = lead_len(b);
          if (len == 3'd0) u8_bad = 1'b1;
          else begin
            u8_lead        = b;
            u8_left        = 2'(len - 3'd1);
            u8_err_pending = 1'b0;
          end
        end
      end else begin
        bad = (b[7:6] != 2'b10);
        // tighter range on the byte right after some leads
        if ({1'b0, u8_left} == lead_len(u8_lead) - 3'd1) begin
          if (u8_lead == ugd_pkg::U3_LEAD_E0 && b < ugd_pkg::BOUND_A0) bad = 1'b1;
          if (u8_lead == ugd_pkg::U3_LEAD_ED && b >= ugd_pkg::BOUND_A0) bad = 1'b1;
          if (u8_lead == ugd_pkg::U4_LEAD_MIN && b < ugd_pkg::BOUND_90) bad = 1'b1;
          if (u8_lead == ugd_pkg::U4_LEAD_MAX && b >= ugd_pkg::BOUND_90) bad = 1'b1;
        end
        if (bad) u8_err_pending = 1'b1;
        u8_left = u8_left - 2'd1;
        if (u8_left == 2'd0) begin
          if (u8_err_pending) u8_bad = 1'b1;
          u8_err_pending = 1'b0;
        end
      end

      if (gbk_need_trail) begin
        if (b < ugd_pkg::GBK_TRAIL_MIN || b > ugd_pkg::GBK_TRAIL_MAX ||
            b == ugd_pkg::GBK_TRAIL_BAD) gbk_bad = 1'b1;
        gbk_need_trail = 1'b0;
      end else if (b >= ugd_pkg::HIGH_MIN) begin
        if (b >= ugd_pkg::GBK_LEAD_MIN && b <= ugd_pkg::GBK_LEAD_MAX) gbk_need_trail = 1'b1;
        else gbk_bad = 1'b1;
      end
    end

    if (fin) begin
      v.bom = bom_flag;
      if (bom_flag || !window_open) v.enc = ugd_pkg::ENC_UTF8;
      else v.enc = (u8_bad && !gbk_bad) ? ugd_pkg::ENC_GBK : ugd_pkg::ENC_UTF8;
      verdict_q.push_back(v);
      clear_state();
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      clear_state();
      verdict_q.delete();
      mismatches = 0;
    end else begin
      // the verdict leaving now belongs to an earlier byte, so check it first
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected verdict, expected none, actual encoding %0d has_bom %0d",
                   $time, encoding, has_bom);
        end else begin
          want = verdict_q.pop_front();
          if (encoding !== want.enc) begin
            mismatches++;
            $display("%0t: encoding mismatch, expected %0d, actual %0d",
                     $time, want.enc, encoding);
          end
          if (has_bom !== want.bom) begin
            mismatches++;
            $display("%0t: has_bom mismatch, expected %0d, actual %0d",
                     $time, want.bom, has_bom);
          end
        end
      end
      if (in_valid && in_ready) absorb_byte(data_byte, last_byte);
    end
    verdicts_owed = verdict_q.size();
  end

endmodule

// File: dv/utf8_gbk_encoding_detector_unit_tb.sv
// ----------------------------------------------------------------------------
// utf8_gbk_encoding_detector_unit_tb: testbench top for the encoding detector
// Sends short directed files, then random files, mostly well-formed UTF-8 or
// GBK text with some corruption and noise. The sender idles in bursts and the
// verdict side stalls on its own.
// ----------------------------------------------------------------------------
module utf8_gbk_encoding_detector_unit_tb;

  localparam int QUIET_LIMIT = 500;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'd0;
  logic       last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic       encoding;
  logic       has_bom;

  int mismatches;
  int verdicts_owed;

  logic [7:0] text_q[$];
  int         burst_left  = 0;
  int         stall_left  = 0;
  int         calm_left   = 0;
  int         quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  utf8_gbk_encoding_detector_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .encoding  (encoding),
    .has_bom   (has_bom)
  );

  ugd_verdict_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .encoding      (encoding),
    .has_bom       (has_bom),
    .mismatches    (mismatches),
    .verdicts_owed (verdicts_owed)
  );

  // verdict side: short random stalls, with calm stretches of no stall
  always @(posedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      case ($urandom_range(0, 15))
        0:       calm_left = $urandom_range(50, 300);
        1, 2, 3: stall_left = $urandom_range(1, 12);
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic fin);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 12);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    // ready is looked at mid-cycle, the beat goes at the next edge
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    burst_left--;
  endtask

  task automatic send_file();
    for (int i = 0; i < text_q.size(); i++) send_beat(text_q[i], i == text_q.size() - 1);
  endtask

  // hold off until every verdict owed has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (verdicts_owed != 0);
    @(posedge clk);
  endtask

  task automatic add_ascii();
    text_q.push_back(8'($urandom_range(0, 127)));
  endtask

  task automatic add_cont();
    text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
  endtask

  task automatic add_utf8_char(input int nbytes);
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hbf;
    case (nbytes)
      1: add_ascii();
      2: begin
        text_q.push_back(8'($urandom_range(ugd_pkg::U2_LEAD_MIN, ugd_pkg::U2_LEAD_MAX)));
        add_cont();
      end
      3: begin
        lead = 8'($urandom_range(ugd_pkg::U3_LEAD_MIN, ugd_pkg::U3_LEAD_MAX));
        if (lead == ugd_pkg::U3_LEAD_E0) lo = ugd_pkg::BOUND_A0;
        if (lead == ugd_pkg::U3_LEAD_ED) hi = 8'h9f;
        text_q.push_back(lead);
        text_q.push_back(8'($urandom_range(lo, hi)));
        add_cont();
      end
      default: begin
        lead = 8'($urandom_range(ugd_pkg::U4_LEAD_MIN, ugd_pkg::U4_LEAD_MAX));
        if (lead == ugd_pkg::U4_LEAD_MIN) lo = ugd_pkg::BOUND_90;
        if (lead == ugd_pkg::U4_LEAD_MAX) hi = 8'h8f;
        text_q.push_back(lead);
        text_q.push_back(8'($urandom_range(lo, hi)));
        add_cont();
        add_cont();
      end
    endcase
  endtask

  task automatic add_gbk_char();
    logic [7:0] trail;
    trail = 8'($urandom_range(ugd_pkg::GBK_TRAIL_MIN, ugd_pkg::GBK_TRAIL_MAX));
    if (trail == ugd_pkg::GBK_TRAIL_BAD) trail = 8'h80;
    text_q.push_back(8'($urandom_range(ugd_pkg::GBK_LEAD_MIN, ugd_pkg::GBK_LEAD_MAX)));
    text_q.push_back(trail);
  endtask

  task automatic build_random_file();
    int style;
    int nchars;
    int cut;
    style  = $urandom_range(0, 9);
    nchars = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    text_q.delete();
    // full or partial byte order mark up front now and then
    if ($urandom_range(0, 5) == 0) begin
      text_q.push_back(ugd_pkg::BOM_B0);
      if ($urandom_range(0, 3) != 0) text_q.push_back(ugd_pkg::BOM_B1);
      if ($urandom_range(0, 3) != 0) text_q.push_back(ugd_pkg::BOM_B2);
    end
    repeat (nchars) begin
      case (style)
        0:       add_ascii();
        1, 2, 3: add_utf8_char($urandom_range(1, 4));
        4, 5, 6: if ($urandom_range(0, 3) == 0) add_ascii(); else add_gbk_char();
        7:       if ($urandom_range(0, 1) == 0) add_utf8_char($urandom_range(1, 4));
                 else add_gbk_char();
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (style >= 1 && style <= 7 && $urandom_range(0, 3) == 0)
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    // chop the tail so sequences get cut off by the final byte
    if (text_q.size() > 1 && $urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, 3);
      while (cut > 0 && text_q.size() > 1) begin
        void'(text_q.pop_back());
        cut--;
      end
    end
  endtask

  initial begin
    int beats_sent;
    int files_sent;
    beats_sent = 0;
    files_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    text_q = '{8'h00, 8'h7f};                       send_file();
    text_q = '{ugd_pkg::BOM_B0};                    send_file();
    text_q = '{ugd_pkg::BOM_B0, ugd_pkg::BOM_B1};   send_file();
    text_q = '{ugd_pkg::BOM_B0, ugd_pkg::BOM_B1, ugd_pkg::BOM_B2};
    send_file();
    text_q = '{ugd_pkg::BOM_B0, ugd_pkg::BOM_B1, ugd_pkg::BOM_B2, 8'h80, 8'hff};
    send_file();
    text_q = '{8'hc4, 8'he3};                       send_file();
    text_q = '{8'h80, 8'hff};                       send_file();
    text_q = '{8'hfe, 8'h40};                       send_file();
    text_q = '{8'he0, 8'h9f};                       send_file();
    text_q = '{8'hed, 8'ha0, 8'h80};                send_file();
    text_q = '{8'hf4, 8'h90, 8'h80, 8'h80};         send_file();
    drain();

    while (beats_sent < 1020 || files_sent < 40) begin
      build_random_file();
      beats_sent += text_q.size();
      files_sent++;
      send_file();
      if ($urandom_range(0, 11) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && verdicts_owed == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
